// File: hdl/block_cache_tag_lru_controller_core_assert.svh
// assertion macros used by the checker file
`ifndef BLOCK_CACHE_TAG_LRU_CONTROLLER_CORE_ASSERT_SVH
`define BLOCK_CACHE_TAG_LRU_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define BCTL_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define BCTL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/bctl_pkg.sv
package bctl_pkg;

   // widest slot index over the supported cache sizes
   localparam int IDX_W = 10;

   typedef enum logic [1:0] {
      KIND_GET     = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_FLUSH   = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_HIT        = 3'd0,
      ST_MISS       = 3'd1,
      ST_WAIT       = 3'd2,
      ST_BUSY       = 3'd3,
      ST_RELEASED   = 3'd4,
      ST_NO_MATCH   = 3'd5,
      ST_FLUSH_WB   = 3'd6,
      ST_FLUSH_DONE = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_UNPIN   = 3'd1,
      OP_GRANT   = 3'd2,
      OP_FILL    = 3'd3,
      OP_RELEASE = 3'd4
   } op_type;

   // command broadcast to every cell
   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
      logic [31:0]      stamp;
      logic             modified;
   } cmd_type;

   // search state handed from cell to cell
   typedef struct packed {
      logic             hit_found;
      logic             hit_wait;
      logic [IDX_W-1:0] hit_idx;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic             lru_found;
      logic             lru_dirty;
      logic [IDX_W-1:0] lru_idx;
      logic [31:0]      lru_stamp;
      logic [31:0]      lru_tag;
   } carry_type;

   // dirty slot seen by the flush token, zero elsewhere
   typedef struct packed {
      logic             dirty;
      logic [IDX_W-1:0] idx;
      logic [31:0]      tag;
   } probe_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  result_slot;
      logic        writeback_needed;
      logic [31:0] writeback_block;
      logic        last;
   } result_type;

endpackage

// File: hdl/bctl_if.sv
interface bctl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] block_number;
   logic [7:0]  requester;
   logic [5:0]  slot;
   logic        modified;

   modport source (output valid, kind, block_number, requester, slot, modified,
                   input ready);
   modport sink (input valid, kind, block_number, requester, slot, modified,
                 output ready);
endinterface

interface bctl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  result_slot;
   logic        writeback_needed;
   logic [31:0] writeback_block;
   logic        last;

   modport source (output valid, status, result_slot, writeback_needed,
                   writeback_block, last, input ready);
   modport sink (input valid, status, result_slot, writeback_needed,
                 writeback_block, last, output ready);
endinterface

// File: hdl/bctl_cell.sv
module bctl_cell #(
   parameter int IDX        = 0,
   parameter int OWNER_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    flush_mode,
   input  logic                    tok_in,
   input  bctl_pkg::carry_type     carry_in,
   input  logic [31:0]             blk,
   input  logic [OWNER_BITS-1:0]   who,
   input  bctl_pkg::cmd_type       cmd,
   output logic                    tok_out,
   output bctl_pkg::carry_type     carry_out,
   output bctl_pkg::probe_type     probe,
   output logic                    ack
);

   localparam logic [bctl_pkg::IDX_W-1:0] MY_IDX = bctl_pkg::IDX_W'(IDX);

   logic                  valid_ff, valid_in;
   logic                  dirty_ff, dirty_in;
   logic                  pinned_ff, pinned_in;
   logic [31:0]           tag_ff, tag_in;
   logic [31:0]           stamp_ff, stamp_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic                  tok_ff, tok_in_nx;
   bctl_pkg::carry_type   carry_ff, carry_in_nx, carry_upd;
   logic                  sel;
   logic                  flush_hit;

   assign sel       = (cmd.idx == MY_IDX);
   assign flush_hit = tok_in && flush_mode && valid_ff && dirty_ff;

   // fold this slot into the running search
   always_comb begin
      carry_upd = carry_in;
      if (valid_ff && tag_ff == blk && !carry_in.hit_found) begin
         carry_upd.hit_found = 1'b1;
         carry_upd.hit_wait  = pinned_ff && owner_ff != who;
         carry_upd.hit_idx   = MY_IDX;
      end
      if (!valid_ff && !pinned_ff && !carry_in.free_found) begin
         carry_upd.free_found = 1'b1;
         carry_upd.free_idx   = MY_IDX;
      end
      if (valid_ff && !pinned_ff && (!carry_in.lru_found || stamp_ff < carry_in.lru_stamp))
      begin
         carry_upd.lru_found = 1'b1;
         carry_upd.lru_dirty = dirty_ff;
         carry_upd.lru_idx   = MY_IDX;
         carry_upd.lru_stamp = stamp_ff;
         carry_upd.lru_tag   = tag_ff;
      end
   end

   always_comb begin
      tok_in_nx   = advance ? tok_in : tok_ff;
      carry_in_nx = (advance && tok_in) ? carry_upd : carry_ff;
   end

   always_comb begin
      probe.dirty = flush_hit;
      probe.idx   = flush_hit ? MY_IDX : '0;
      probe.tag   = flush_hit ? tag_ff : '0;
   end

   always_comb begin
      unique case (cmd.op)
         bctl_pkg::OP_UNPIN:   ack = sel && pinned_ff && owner_ff == who;
         bctl_pkg::OP_RELEASE: ack = sel && valid_ff;
         default:              ack = 1'b0;
      endcase
   end

   always_comb begin
      valid_in  = valid_ff;
      dirty_in  = dirty_ff;
      pinned_in = pinned_ff;
      tag_in    = tag_ff;
      stamp_in  = stamp_ff;
      owner_in  = owner_ff;
      if (flush_hit && advance) begin
         dirty_in = 1'b0;
      end
      unique case (cmd.op)
         bctl_pkg::OP_UNPIN: begin
            if (ack) begin
               pinned_in = 1'b0;
               owner_in  = '0;
            end
         end
         bctl_pkg::OP_GRANT: begin
            if (sel) begin
               pinned_in = 1'b1;
               owner_in  = who;
               stamp_in  = cmd.stamp;
            end
         end
         bctl_pkg::OP_FILL: begin
            if (sel) begin
               valid_in  = 1'b1;
               dirty_in  = 1'b0;
               tag_in    = blk;
               pinned_in = 1'b1;
               owner_in  = who;
               stamp_in  = cmd.stamp;
            end
         end
         bctl_pkg::OP_RELEASE: begin
            if (ack) begin
               dirty_in  = dirty_ff || cmd.modified;
               pinned_in = 1'b0;
               owner_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         dirty_ff  <= 1'b0;
         pinned_ff <= 1'b0;
         tag_ff    <= '0;
         stamp_ff  <= '0;
         owner_ff  <= '0;
         tok_ff    <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         dirty_ff  <= dirty_in;
         pinned_ff <= pinned_in;
         tag_ff    <= tag_in;
         stamp_ff  <= stamp_in;
         owner_ff  <= owner_in;
         tok_ff    <= tok_in_nx;
      end
      carry_ff <= carry_in_nx;
   end

   assign tok_out   = tok_ff;
   assign carry_out = carry_ff;

endmodule

// File: hdl/block_cache_tag_lru_controller_core.sv
// channel  direction  handshake      payload
// req_ch   in         valid/ready    kind, block_number, requester, slot, modified
// rsp_ch   out        valid/ready    status, result_slot, writeback_needed,
//                                    writeback_block, last
//
// a get runs through accept, unpin of the last handed slot, launch of the search
// token, one cell per cycle while it walks the chain, then the decision; a
// release runs through accept, then the decision
// a flush runs through accept, one cell per cycle, token exit and the final
// result, but the token waits on a dirty slot, and so on any stall on rsp_ch,
// until its transaction can be held; a get or release waits in its decision
// cycle until the output register is free
// reset (synchronous) empties every slot and drops any token in flight
// one transaction is worked at a time; the next is taken while a result still
// waits in the output register
module block_cache_tag_lru_controller_core #(
   parameter int ENTRIES    = 64,
   parameter int OWNER_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   bctl_req_if.sink    req_ch,
   bctl_rsp_if.source  rsp_ch
);

   localparam int IW = bctl_pkg::IDX_W;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_UNPIN = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_GDONE = 7'b0001000,
      S_REL   = 7'b0010000,
      S_FLUSH = 7'b0100000,
      S_FEND  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // latched transaction
   logic [31:0]           blk_ff, blk_in;
   logic [OWNER_BITS-1:0] who_ff, who_in;
   logic [5:0]            slot_ff, slot_in;
   logic                  mod_ff, mod_in;
   logic [OWNER_BITS+7:0] who_ext;

   // replacement bookkeeping
   logic [31:0]   clock_ff, clock_in;
   logic          last_v_ff, last_v_in;
   logic [IW-1:0] last_idx_ff, last_idx_in;
   logic          go_ff, go_in;

   // held flush result and output register
   bctl_pkg::result_type pend_ff, pend_in, rsp_ff, rsp_in;
   logic                 pend_v_ff, pend_v_in, rsp_v_ff, rsp_v_in;

   // chain
   logic                tok[ENTRIES];
   bctl_pkg::carry_type carry[ENTRIES];
   bctl_pkg::probe_type probes[ENTRIES];
   logic                acks[ENTRIES];
   bctl_pkg::probe_type probe_all;
   logic                ack_all;
   bctl_pkg::cmd_type   cmd;
   bctl_pkg::carry_type fc;

   logic advance, rsp_free, can_take, accept, in_range, flush_mode;
   logic                 load_en;
   bctl_pkg::result_type load_val;

   assign who_ext  = {{OWNER_BITS{1'b0}}, req_ch.requester};
   assign accept   = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_v_ff || rsp_ch.ready;
   assign can_take = !pend_v_ff || rsp_free;
   assign flush_mode = (state_ff == S_FLUSH);
   assign advance  = flush_mode ? (!probe_all.dirty || can_take) : 1'b1;
   assign in_range = ({5'b0, slot_ff} < 11'(ENTRIES));
   assign fc       = carry[ENTRIES-1];

   // at most one cell drives its probe or ack at a time, so an OR merges them
   always_comb begin
      probe_all = '0;
      ack_all   = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         probe_all = probe_all | probes[i];
         ack_all   = ack_all | acks[i];
      end
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      bctl_cell #(
         .IDX        (g),
         .OWNER_BITS (OWNER_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .flush_mode (flush_mode),
         .tok_in     ((g == 0) ? go_ff : tok[(g == 0) ? 0 : g-1]),
         .carry_in   ((g == 0) ? '0 : carry[(g == 0) ? 0 : g-1]),
         .blk        (blk_ff),
         .who        (who_ff),
         .cmd        (cmd),
         .tok_out    (tok[g]),
         .carry_out  (carry[g]),
         .probe      (probes[g]),
         .ack        (acks[g])
      );
   end

   always_comb begin
      state_in    = state_ff;
      blk_in      = blk_ff;
      who_in      = who_ff;
      slot_in     = slot_ff;
      mod_in      = mod_ff;
      clock_in    = clock_ff;
      last_v_in   = last_v_ff;
      last_idx_in = last_idx_ff;
      go_in       = go_ff && !advance;
      pend_in     = pend_ff;
      pend_v_in   = pend_v_ff;
      cmd         = '0;
      cmd.op      = bctl_pkg::OP_NONE;
      load_en     = 1'b0;
      load_val    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               blk_in  = req_ch.block_number;
               who_in  = who_ext[OWNER_BITS-1:0];
               slot_in = req_ch.slot;
               mod_in  = req_ch.modified;
               unique case (req_ch.kind)
                  bctl_pkg::KIND_GET:     state_in = S_UNPIN;
                  bctl_pkg::KIND_RELEASE: state_in = S_REL;
                  bctl_pkg::KIND_FLUSH: begin
                     go_in    = 1'b1;
                     state_in = S_FLUSH;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_UNPIN: begin
            // drop the requester's own pin on the last handed slot
            if (last_v_ff) begin
               cmd.op  = bctl_pkg::OP_UNPIN;
               cmd.idx = last_idx_ff;
            end
            if (ack_all) begin
               last_v_in = 1'b0;
            end
            go_in    = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (tok[ENTRIES-1]) begin
               state_in = S_GDONE;
            end
         end
         S_GDONE: begin
            if (rsp_free) begin
               load_en      = 1'b1;
               load_val.last = 1'b1;
               state_in     = S_IDLE;
               priority if (fc.hit_found) begin
                  load_val.result_slot = fc.hit_idx[5:0];
                  if (fc.hit_wait) begin
                     load_val.status = bctl_pkg::ST_WAIT;
                  end else begin
                     load_val.status = bctl_pkg::ST_HIT;
                     cmd.op          = bctl_pkg::OP_GRANT;
                     cmd.idx         = fc.hit_idx;
                     cmd.stamp       = clock_ff + 32'd1;
                     clock_in        = clock_ff + 32'd1;
                     last_v_in       = 1'b1;
                     last_idx_in     = fc.hit_idx;
                  end
               end else if (fc.free_found || fc.lru_found) begin
                  // first free slot wins over the least recently used one
                  load_val.status = bctl_pkg::ST_MISS;
                  cmd.op          = bctl_pkg::OP_FILL;
                  cmd.idx         = fc.free_found ? fc.free_idx : fc.lru_idx;
                  cmd.stamp       = clock_ff + 32'd1;
                  clock_in        = clock_ff + 32'd1;
                  last_v_in       = 1'b1;
                  last_idx_in     = cmd.idx;
                  load_val.result_slot = cmd.idx[5:0];
                  if (!fc.free_found && fc.lru_dirty) begin
                     load_val.writeback_needed = 1'b1;
                     load_val.writeback_block  = fc.lru_tag;
                  end
               end else begin
                  load_val.status = bctl_pkg::ST_BUSY;
               end
            end
         end
         S_REL: begin
            if (rsp_free) begin
               if (in_range) begin
                  cmd.op       = bctl_pkg::OP_RELEASE;
                  cmd.idx      = IW'(slot_ff);
                  cmd.modified = mod_ff;
               end
               load_en              = 1'b1;
               load_val.status      = ack_all ? bctl_pkg::ST_RELEASED : bctl_pkg::ST_NO_MATCH;
               load_val.result_slot = slot_ff;
               load_val.last        = 1'b1;
               state_in             = S_IDLE;
            end
         end
         S_FLUSH: begin
            // hold one dirty slot back so the final one can carry last
            if (probe_all.dirty && can_take) begin
               if (pend_v_ff) begin
                  load_en  = 1'b1;
                  load_val = pend_ff;
               end
               pend_v_in                = 1'b1;
               pend_in.status           = bctl_pkg::ST_FLUSH_WB;
               pend_in.result_slot      = probe_all.idx[5:0];
               pend_in.writeback_needed = 1'b1;
               pend_in.writeback_block  = probe_all.tag;
               pend_in.last             = 1'b0;
            end
            if (tok[ENTRIES-1]) begin
               state_in = S_FEND;
            end
         end
         S_FEND: begin
            if (rsp_free) begin
               load_en = 1'b1;
               if (pend_v_ff) begin
                  load_val = pend_ff;
               end else begin
                  load_val.status = bctl_pkg::ST_FLUSH_DONE;
               end
               load_val.last = 1'b1;
               pend_v_in     = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in   = load_en ? load_val : rsp_ff;
      rsp_v_in = load_en || (rsp_v_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         clock_ff    <= '0;
         last_v_ff   <= 1'b0;
         last_idx_ff <= '0;
         go_ff       <= 1'b0;
         pend_v_ff   <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clock_ff    <= clock_in;
         last_v_ff   <= last_v_in;
         last_idx_ff <= last_idx_in;
         go_ff       <= go_in;
         pend_v_ff   <= pend_v_in;
         rsp_v_ff    <= rsp_v_in;
      end
      blk_ff  <= blk_in;
      who_ff  <= who_in;
      slot_ff <= slot_in;
      mod_ff  <= mod_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ch.ready            = (state_ff == S_IDLE);
   assign rsp_ch.valid            = rsp_v_ff;
   assign rsp_ch.status           = rsp_ff.status;
   assign rsp_ch.result_slot      = rsp_ff.result_slot;
   assign rsp_ch.writeback_needed = rsp_ff.writeback_needed;
   assign rsp_ch.writeback_block  = rsp_ff.writeback_block;
   assign rsp_ch.last             = rsp_ff.last;

endmodule

// File: hdl/bctl_checker.sv
`include "block_cache_tag_lru_controller_core_assert.svh"

module bctl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic        rsp_wb_needed,
   input logic [31:0] rsp_wb_block
);

   // a result held back by the sink stays offered
   `BCTL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")

   // any real transaction makes the block drop req_ready in the cycle after it is taken
   `BCTL_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready && req_kind != bctl_pkg::KIND_NONE, !req_ready, "req taken twice in a row")

   // a flushed slot always asks for writeback
   `BCTL_ASSERT_SAME(a_flush_wb, rsp_valid && rsp_status == bctl_pkg::ST_FLUSH_WB, rsp_wb_needed, "flush result without writeback")

   // results other than a miss or a flush writeback never name a writeback block
   `BCTL_ASSERT_SAME(a_no_wb, rsp_valid && (rsp_status == bctl_pkg::ST_HIT || rsp_status == bctl_pkg::ST_WAIT || rsp_status == bctl_pkg::ST_BUSY || rsp_status == bctl_pkg::ST_RELEASED || rsp_status == bctl_pkg::ST_NO_MATCH || rsp_status == bctl_pkg::ST_FLUSH_DONE), !rsp_wb_needed && rsp_wb_block == 32'd0, "stray writeback")

endmodule

bind block_cache_tag_lru_controller_core bctl_checker u_bctl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_kind      (req_ch.kind),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_wb_needed (rsp_ch.writeback_needed),
   .rsp_wb_block  (rsp_ch.writeback_block)
);
